### hdl/kvt_pkg.sv
// kvt_pkg: shared types and constants of the key-value table
// action and status codes, request and slot entry formats, stream widths
// no dependencies
package kvt_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 40;
  localparam int QUEUE_DEPTH = 2;

  // action codes on the input stream
  localparam logic [ACTION_W-1:0] ACTION_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACTION_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACTION_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REMOVE,
    OP_NONE
  } kvt_op_t;

  typedef struct packed {
    kvt_op_t                  op;
    logic signed [KEY_W-1:0]  key;
    logic        [VAL_W-1:0]  value;
  } kvt_req_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic     valid;
    kvt_req_t req;
  } kvt_head_t;

  // back end control toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } kvt_back_ctl_t;

  typedef struct packed {
    logic                     valid;
    logic signed [KEY_W-1:0]  key;
    logic        [VAL_W-1:0]  value;
  } kvt_entry_t;

endpackage

### hdl/kvt_front.sv
// kvt_front: input side of the key-value table
// accepts stream requests, decodes the action and queues them for the back end
// depends on kvt_pkg
module kvt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kvt_pkg::S_TDATA_W-1:0]   s_tdata,
  output kvt_pkg::kvt_head_t              head,
  input  kvt_pkg::kvt_back_ctl_t          back_ctl
);
  import kvt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  kvt_req_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     fill;
  logic                 push;
  logic                 pop;
  kvt_req_t             in_req;
  logic [ACTION_W-1:0]  action;

  assign action = s_tdata[ACTION_W-1:0];

  always_comb begin
    case (action)
      ACTION_INSERT: in_req.op = OP_INSERT;
      ACTION_LOOKUP: in_req.op = OP_LOOKUP;
      ACTION_REMOVE: in_req.op = OP_REMOVE;
      default:       in_req.op = OP_NONE;
    endcase
    in_req.key   = s_tdata[ACTION_W +: KEY_W];
    in_req.value = s_tdata[ACTION_W + KEY_W +: VAL_W];
  end

  assign s_tready   = (fill != CNT_W'(QUEUE_DEPTH)) && !back_ctl.clearing;
  assign push       = s_tvalid && s_tready;
  assign pop        = back_ctl.pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.req   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/kvt_back.sv
// kvt_back: execution side of the key-value table
// holds the slot memory, scans it per request, writes back and registers the result
// depends on kvt_pkg
module kvt_back #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kvt_pkg::kvt_head_t              head,
  output kvt_pkg::kvt_back_ctl_t          back_ctl,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kvt_pkg::M_TDATA_W-1:0]   m_tdata
);
  import kvt_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state;
  kvt_entry_t         mem [ENTRIES];
  kvt_entry_t         rd_data;
  kvt_req_t           req;
  logic [CNTW-1:0]    issue_cnt;
  logic [CNTW-1:0]    clr_cnt;
  logic [CNTW-1:0]    entry_count;
  logic [CNTW-1:0]    count_next;
  logic               chk_vld;
  logic [IDXW-1:0]    chk_idx;
  logic               hit;
  logic [IDXW-1:0]    hit_idx;
  logic [VAL_W-1:0]   hit_value;
  logic               free_found;
  logic [IDXW-1:0]    free_idx;
  logic               match;
  logic               done_fire;
  logic               mem_we;
  logic [IDXW-1:0]    mem_waddr;
  kvt_entry_t         mem_wdata;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]   res_value;

  assign match     = rd_data.valid && (rd_data.key == req.key);
  assign done_fire = (state == S_DONE) && (!m_tvalid || m_tready);

  assign back_ctl.pop      = (state == S_IDLE) && head.valid;
  assign back_ctl.clearing = (state == S_CLEAR);

  // outcome of the finished scan and the slot write it causes, or the clearing write during the clearing pass
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_value  = '0;
    count_next = entry_count;
    mem_we     = 1'b0;
    mem_waddr  = hit_idx;
    mem_wdata  = '{valid: 1'b1, key: req.key, value: req.value};
    case (req.op)
      OP_INSERT: begin
        if (hit) begin
          res_status = ST_UPDATED;
          mem_we     = done_fire;
        end else if (free_found) begin
          res_status = ST_INSERTED;
          mem_we     = done_fire;
          mem_waddr  = free_idx;
          count_next = entry_count + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res_status = ST_FOUND;
          res_value  = hit_value;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          res_status      = ST_REMOVED;
          mem_we          = done_fire;
          mem_wdata.valid = 1'b0;
          if (entry_count != '0) begin
            count_next = entry_count - 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[IDXW-1:0];
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[issue_cnt[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      issue_cnt   <= '0;
      entry_count <= '0;
      chk_vld     <= 1'b0;
      hit         <= 1'b0;
      free_found  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !done_fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CNTW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            req        <= head.req;
            issue_cnt  <= '0;
            chk_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_cnt < CNTW'(ENTRIES)) begin
            issue_cnt <= issue_cnt + 1'b1;
            chk_vld   <= 1'b1;
            chk_idx   <= issue_cnt[IDXW-1:0];
          end else begin
            chk_vld <= 1'b0;
          end
          if (chk_vld) begin
            if (match) begin
              hit       <= 1'b1;
              hit_idx   <= chk_idx;
              hit_value <= rd_data.value;
            end else if (!rd_data.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (match || (chk_idx == IDXW'(ENTRIES - 1))) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_fire) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= {COUNT_W'(count_next), res_value, res_status};
            entry_count <= count_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNTW'(ENTRIES))
    else $error("entry count above slot count");

  // a refused insert only happens with every slot taken
  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (done_fire && (res_status == ST_FULL)) |-> (entry_count == CNTW'(ENTRIES)))
    else $error("table full reported with free slots");

  // slot writes only during the clearing pass or write-back
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_CLEAR) || done_fire))
    else $error("slot write outside clear or write-back");

  // each write-back presents a result on the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> m_tvalid)
    else $error("write-back without result");

endmodule

### hdl/key_value_table_core.sv
// key_value_table_core: top level of the bounded key-value table
// ties the request front end, request queue and scanning back end together
// depends on kvt_pkg, kvt_front, kvt_back
//
// A table of ENTRIES slots, each holding a 32-bit key and a 32-bit value. Every
// request on the slave stream asks to insert or update, look up or remove a key,
// and yields exactly one result on the master stream with a status, the value
// found by a lookup (zero otherwise) and the entry count after the request.
// An insert of a new key into a full table stores nothing and reports table full;
// action code 3 changes nothing and reports not found. Requests are queued two
// deep in the front end, so until the queue is full the slave side keeps
// accepting while the back end works or while a result waits in the output
// register. The back end serves one request at a time: it takes the request,
// scans the slot memory one slot per cycle through its single registered read
// port (stopping early when the key is found), then writes back and loads the
// result into the output register, waiting while a previous result is still
// unaccepted. After reset a clearing pass marks every slot free; s_tready
// stays low during that pass.
module key_value_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // action [1:0], key [33:2], value [65:34], zero pad [71:66]
  input  logic [kvt_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [2:0], value_out [34:3], count [39:35]
  output logic [kvt_pkg::M_TDATA_W-1:0]   m_tdata
);
  import kvt_pkg::*;

  // head of the request queue toward the back end
  kvt_head_t     head;
  // pop and clearing indication back to the front end
  kvt_back_ctl_t back_ctl;

  kvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .back_ctl (back_ctl)
  );

  kvt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .back_ctl (back_ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
